// File: rtl/omd_pkg.sv
// Package for the odometry motion decomposition block: beat types, constants,
// CORDIC arctangent table and small angle helpers. No dependencies.
`default_nettype none
package omd_pkg;

	localparam int CordicStepsDef = 16;
	localparam int CordicMax      = 24;

	localparam logic signed [17:0] PiQ13    = 18'sd25736;
	localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
	localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
	localparam logic signed [31:0] PiQ24    = 32'sd52707179;

	localparam logic [1:0] RegTurnGain = 2'd0;
	localparam logic [1:0] RegMoveGain = 2'd1;
	localparam logic [1:0] RegMinMove  = 2'd2;
	localparam logic [1:0] RegMinTurn  = 2'd3;

	typedef struct packed {
		logic               command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
	} in_beat_t;

	typedef struct packed {
		logic               moved;
		logic signed [31:0] translation;
		logic signed [15:0] first_turn;
		logic signed [15:0] second_turn;
		logic        [13:0] first_turn_spread;
		logic        [23:0] move_spread;
		logic        [13:0] second_turn_spread;
	} out_beat_t;

	// CORDIC datapath word handed from cell to cell
	typedef struct packed {
		logic signed [43:0] x;
		logic signed [43:0] y;
		logic signed [31:0] z;
	} cordic_t;

	function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0: r = 32'sd13176795;
			5'd1: r = 32'sd7778716;
			5'd2: r = 32'sd4110060;
			5'd3: r = 32'sd2086331;
			5'd4: r = 32'sd1047214;
			5'd5: r = 32'sd524117;
			5'd6: r = 32'sd262123;
			5'd7: r = 32'sd131069;
			default: r = 32'sd1 <<< (5'd24 - i);
		endcase
		return r;
	endfunction

	// Wrap into [-pi, pi]; input within +-3*pi
	function automatic logic signed [17:0] wrap1(input logic signed [17:0] v);
		logic signed [17:0] r;
		r = v;
		if (v > PiQ13) r = v - TwoPiQ13;
		else if (v < -PiQ13) r = v + TwoPiQ13;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/omd_cordic_cell.sv
// One CORDIC vectoring cell: a fixed micro-rotation, registered output.
// Depends on omd_pkg.
`default_nettype none
module omd_cordic_cell import omd_pkg::*; #(
	parameter int Shift = 0
) (
	input  wire            clk,
	input  wire cordic_t   d,
	output cordic_t        q_s1
);
	localparam logic [4:0] Idx = 5'(Shift);
	cordic_t n;

	// rotate toward the x axis
	always_comb begin
		if (d.y > 0) begin
			n.x = d.x + (d.y >>> Shift);
			n.y = d.y - (d.x >>> Shift);
			n.z = d.z + atan_q24(Idx);
		end else begin
			n.x = d.x - (d.y >>> Shift);
			n.y = d.y + (d.x >>> Shift);
			n.z = d.z - atan_q24(Idx);
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= n;
	end
endmodule
`default_nettype wire

// File: rtl/omd_isqrt.sv
// Bit-serial integer square root, one result bit per cycle over 64-bit operands.
// Depends on omd_pkg for nothing but house style imports.
`default_nettype none
module omd_isqrt import omd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] radicand,
	output logic [31:0] root_q,
	output logic        done_q
);
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// restoring square root, one bit pair a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q && bit_q != 64'd0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root_q = res_q[31:0];
endmodule
`default_nettype wire

// File: rtl/odometry_motion_decompose.sv
// Top level of the odometry motion decomposition block: registers, sequencer,
// CORDIC cell chain and shared square root. Depends on omd_pkg, omd_cordic_cell, omd_isqrt.
//
//  channel | dir | beat / handshake
//  in      | in  | in_beat_t  : in_valid / in_stall
//  out     | out | out_beat_t : out_valid / out_stall
//  cfg     | in  | APB: psel penable pwrite paddr pwdata prdata pready
//
// One item at a time. An update that moves forms the differences, takes the magnitude
// root (the CORDIC cell chain, CORDIC_STEPS up to 32, fills behind it), makes the moved
// test, takes the three spread roots and loads the result. Below both thresholds an
// update skips the spread roots, and a set-pose command goes straight to the result;
// the next beat is taken in the cycle after the result is loaded.
// Reset clears control and state. A finished result waits in the output register
// while out_stall is high; the next item runs meanwhile up to its own result.
`default_nettype none
module odometry_motion_decompose import omd_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_beat,
	output logic             out_valid,
	input  wire              out_stall,
	output out_beat_t        out_beat,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire  [3:0]       paddr,
	input  wire  [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int CntW = $clog2(CORDIC_STEPS + 2);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_PREP  = 8'b00000010,
		S_NORM  = 8'b00000100,
		S_CORD  = 8'b00001000,
		S_MAG   = 8'b00010000,
		S_TURN  = 8'b00100000,
		S_SPRD  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	logic [15:0] turn_gain_q, move_gain_q;
	logic [30:0] min_move_q;
	logic [14:0] min_turn_q;

	logic signed [31:0] prev_x_q, prev_y_q;
	logic signed [15:0] prev_h_q;
	logic               started_q;
	logic [13:0] fsp_q, ssp_q;
	logic [23:0] msp_q;

	in_beat_t  item_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [17:0] dth_q;
	cordic_t  norm_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0] sq_sel_q;
	logic [31:0] mag_q;
	logic signed [17:0] r1_q, r2_q;
	logic rev_q, moved_q, zero_q;
	logic [63:0] sq_in;
	logic sq_start;
	logic [31:0] sq_root;
	logic sq_done;
	logic [47:0] prod_q;
	out_beat_t res_q;
	logic out_fire;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			RegTurnGain: prdata = {16'd0, turn_gain_q};
			RegMoveGain: prdata = {16'd0, move_gain_q};
			RegMinMove:  prdata = {1'b0, min_move_q};
			RegMinTurn:  prdata = {17'd0, min_turn_q};
			default:     prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q <= 16'd328;
			move_gain_q <= 16'd1638;
			min_move_q  <= 31'd164;
			min_turn_q  <= 15'd164;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegTurnGain: turn_gain_q <= pwdata[15:0];
				RegMoveGain: move_gain_q <= pwdata[15:0];
				RegMinMove:  min_move_q  <= pwdata[30:0];
				RegMinTurn:  min_turn_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// ---------------- CORDIC cell chain ----------------
	cordic_t chain [0:CORDIC_STEPS];
	assign chain[0] = norm_q;
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		omd_cordic_cell #(.Shift(g)) u_cell (
			.clk  (clk),
			.d    (chain[g]),
			.q_s1 (chain[g+1])
		);
	end

	// bearing from chain end, rounded to Q2.13 and wrapped
	logic signed [31:0] zr;
	logic signed [17:0] bear, r1a, r1b;
	always_comb begin
		zr   = (chain[CORDIC_STEPS].z + 32'sd1024) >>> 11;
		bear = zero_q ? 18'sd0 : wrap1(zr[17:0]);
		r1a  = wrap1(bear - 18'(prev_h_q));
		r1b  = (r1a > HalfPiQ13 || r1a < -HalfPiQ13) ? wrap1(r1a - PiQ13) : r1a;
	end

	// ---------------- square root unit ----------------
	omd_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.root_q   (sq_root),
		.done_q   (sq_done)
	);

	logic [31:0] adx, ady;
	assign adx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign ady = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
	logic sat_mag;
	assign sat_mag = adx[31] | ady[31];

	logic [17:0] abs_r1, abs_r2, abs_dth;
	assign abs_r1  = r1_q[17] ? 18'(-r1_q) : r1_q;
	assign abs_r2  = r2_q[17] ? 18'(-r2_q) : r2_q;
	assign abs_dth = dth_q[17] ? 18'(-dth_q) : dth_q;

	logic [32:0] sr_turn;
	logic [24:0] sr_move;
	assign sr_turn = (33'(sq_root) + 33'd4096) >> 13;
	assign sr_move = 25'((33'(sq_root) + 33'd128) >> 8);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_fire = (state_q == S_OUT) && (!out_valid || !out_stall);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			prev_h_q  <= '0;
			fsp_q     <= '0;
			msp_q     <= '0;
			ssp_q     <= '0;
			out_valid <= 1'b0;
			sq_start  <= 1'b0;
			cnt_q     <= '0;
			sq_sel_q  <= '0;
			moved_q   <= 1'b0;
			mag_q     <= '0;
			rev_q     <= 1'b0;
			r1_q      <= '0;
			r2_q      <= '0;
			zero_q    <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			dth_q     <= '0;
			sq_in     <= '0;
			prod_q    <= '0;
		end else begin
			sq_start <= (state_q == S_NORM) || ((state_q == S_SPRD) && (cnt_q == '0));
			if (out_fire) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_beat.command) begin
							prev_x_q <= in_beat.pos_x;
							prev_y_q <= in_beat.pos_y;
							prev_h_q <= in_beat.heading;
							moved_q  <= 1'b0;
							mag_q    <= '0;
							rev_q    <= 1'b0;
							r1_q     <= '0;
							r2_q     <= '0;
							state_q  <= S_OUT;
						end else begin
							if (!started_q) begin
								prev_x_q <= in_beat.pos_x;
								prev_y_q <= in_beat.pos_y;
								prev_h_q <= in_beat.heading;
								started_q <= 1'b1;
							end
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					dx_q  <= 33'(item_q.pos_x) - 33'(prev_x_q);
					dy_q  <= 33'(item_q.pos_y) - 33'(prev_y_q);
					dth_q <= wrap1(18'(item_q.heading) - 18'(prev_h_q));
					state_q <= S_NORM;
				end
				S_NORM: begin
					zero_q <= (dx_q == 0) && (dy_q == 0);
					// start magnitude root alongside the chain
					sq_in    <= sat_mag ? 64'd0 : 64'(adx) * 64'(adx) + 64'(ady) * 64'(ady);
					cnt_q    <= '0;
					state_q  <= S_CORD;
				end
				S_CORD: begin
					if (cnt_q != CntW'(CORDIC_STEPS + 1)) cnt_q <= cnt_q + 1'b1;
					if (sq_done) begin
						mag_q <= (sat_mag || sq_root[31]) ? 32'h7FFF_FFFF : sq_root;
					end
					if (cnt_q == CntW'(CORDIC_STEPS + 1)) state_q <= S_MAG;
				end
				S_MAG: begin
					if (sq_done) mag_q <= (sat_mag || sq_root[31]) ? 32'h7FFF_FFFF : sq_root;
					r1_q  <= r1b;
					rev_q <= (r1a > HalfPiQ13) || (r1a < -HalfPiQ13);
					r2_q  <= wrap1(dth_q - r1b);
					if (sq_done) state_q <= S_TURN;
				end
				S_TURN: begin
					moved_q <= (mag_q >= 32'(min_move_q)) || (abs_dth >= 18'(min_turn_q));
					if ((mag_q >= 32'(min_move_q)) || (abs_dth >= 18'(min_turn_q))) begin
						prod_q   <= 48'(turn_gain_q) * 48'(abs_r1);
						sq_sel_q <= 2'd0;
						state_q  <= S_SPRD;
						cnt_q    <= '0;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SPRD: begin
					if (cnt_q == '0) begin
						sq_in <= (sq_sel_q == 2'd1) ? {prod_q[47:0], 16'd0} : {prod_q[40:0], 23'd0};
						cnt_q <= CntW'(1);
					end else if (sq_done) begin
						cnt_q <= '0;
						case (sq_sel_q)
							2'd0: begin
								fsp_q <= (sr_turn > 33'd16383) ? 14'h3FFF : sr_turn[13:0];
								prod_q <= 48'(move_gain_q) * 48'(mag_q);
								sq_sel_q <= 2'd1;
							end
							2'd1: begin
								msp_q <= sr_move[24] ? 24'hFF_FFFF : sr_move[23:0];
								prod_q <= 48'(turn_gain_q) * 48'(abs_r2);
								sq_sel_q <= 2'd2;
							end
							default: begin
								ssp_q <= (sr_turn > 33'd16383) ? 14'h3FFF : sr_turn[13:0];
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (out_fire) begin
						if (!item_q.command) begin
							prev_x_q <= item_q.pos_x;
							prev_y_q <= item_q.pos_y;
							prev_h_q <= item_q.heading;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the accepted beat; normalize the vector for the chain
	logic signed [43:0] norm_pre_x_q, norm_pre_y_q;
	logic signed [43:0] norm_lo_x_q, norm_lo_y_q;
	logic signed [43:0] nx, ny;
	always_comb begin
		nx = 44'(dx_q);
		ny = 44'(dy_q);
		for (int k = 0; k < 13; k++) begin
			if ((nx < 44'sh0_0080_0000_0000 && nx > -44'sh0_0080_0000_0000) &&
			    (ny < 44'sh0_0080_0000_0000 && ny > -44'sh0_0080_0000_0000) &&
			    !(nx == 0 && ny == 0)) begin
				nx = nx <<< 1;
				ny = ny <<< 1;
			end
		end
	end
	// last pass of thirteen doublings feeds the chain input register
	logic signed [43:0] mx, my;
	always_comb begin
		mx = norm_pre_x_q;
		my = norm_pre_y_q;
		for (int k = 0; k < 13; k++) begin
			if ((mx < 44'sh0_0080_0000_0000 && mx > -44'sh0_0080_0000_0000) &&
			    (my < 44'sh0_0080_0000_0000 && my > -44'sh0_0080_0000_0000) &&
			    !(mx == 0 && my == 0)) begin
				mx = mx <<< 1;
				my = my <<< 1;
			end
		end
	end
	logic signed [43:0] lx, ly;
	always_comb begin
		lx = norm_lo_x_q;
		ly = norm_lo_y_q;
		for (int k = 0; k < 13; k++) begin
			if ((lx < 44'sh0_0080_0000_0000 && lx > -44'sh0_0080_0000_0000) &&
			    (ly < 44'sh0_0080_0000_0000 && ly > -44'sh0_0080_0000_0000) &&
			    !(lx == 0 && ly == 0)) begin
				lx = lx <<< 1;
				ly = ly <<< 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) item_q <= in_beat;
		// three cascaded doubling steps cover shifts up to 39 over the CORD fill
		norm_lo_x_q  <= nx;
		norm_lo_y_q  <= ny;
		norm_pre_x_q <= lx;
		norm_pre_y_q <= ly;
		if (mx < 0) begin
			norm_q.x <= -mx;
			norm_q.y <= -my;
			norm_q.z <= (my >= 0) ? PiQ24 : -PiQ24;
		end else begin
			norm_q.x <= mx;
			norm_q.y <= my;
			norm_q.z <= '0;
		end
	end

	// load the result beat once the output register is free
	always_ff @(posedge clk) begin
		if (out_fire) begin
			res_q.moved              <= moved_q;
			res_q.translation        <= rev_q ? -mag_q : mag_q;
			res_q.first_turn         <= r1_q[15:0];
			res_q.second_turn        <= r2_q[15:0];
			res_q.first_turn_spread  <= fsp_q;
			res_q.move_spread        <= msp_q;
			res_q.second_turn_spread <= ssp_q;
		end
	end
	assign out_beat = res_q;

	// ---------------- checks ----------------
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_beat)) else $error("stalled beat changed");
	a_sat_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_beat.first_turn_spread <= 14'd16383)) else $error("spread");
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for odometry_motion_decompose: directed table plus random poses,
// checked beat by beat against a fixed-point predictor. Depends on omd_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench import omd_pkg::*; ();

	localparam int NumRandom = 1750;
	localparam logic CmdUpdate = 1'b0;
	localparam logic CmdSetPose = 1'b1;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_beat_t in_beat;
	out_beat_t out_beat;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	odometry_motion_decompose u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state and registers
	longint unsigned turn_gain, move_gain, move_min, turn_min;
	longint pose_x, pose_y, pose_h;
	bit seen_update;
	longint unsigned hold_first, hold_move, hold_second;

	out_beat_t pending_q[$];
	int errors = 0;
	bit quiet_out = 0;
	bit hold_off = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint wrap_angle(longint v);
		while (v > 25736) v -= 51472;
		while (v < -25736) v += 51472;
		return v;
	endfunction

	function automatic longint shr_signed(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint bearing(longint y, longint x);
		longint z, nx, a;
		z = 0;
		if (x == 0 && y == 0) return 0;
		while ((x < 0 ? -x : x) < (64'sd1 <<< 39) && (y < 0 ? -y : y) < (64'sd1 <<< 39)) begin
			x *= 2;
			y *= 2;
		end
		if (x < 0) begin
			z = (y >= 0) ? 52707179 : -52707179;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			a = atan_q24(i[4:0]);
			if (y > 0) begin
				nx = x + shr_signed(y, i);
				y = y - shr_signed(x, i);
				z += a;
			end else begin
				nx = x - shr_signed(y, i);
				y = y + shr_signed(x, i);
				z -= a;
			end
			x = nx;
		end
		return wrap_angle(shr_signed(z + 1024, 11));
	endfunction

	function automatic longint unsigned turn_spread(longint t);
		longint unsigned s;
		s = (int_sqrt((turn_gain * longint'(t < 0 ? -t : t)) << 23) + 4096) >> 13;
		return s > 16383 ? 16383 : s;
	endfunction

	// advance the predictor by one beat and return the expected result
	function automatic out_beat_t decompose_pose(in_beat_t b);
		out_beat_t r;
		longint x, y, h, dx, dy, dth, r1, r2;
		longint unsigned ax, ay, mag, s;
		bit rev, mv;
		x = b.pos_x;
		y = b.pos_y;
		h = b.heading;
		r = '0;
		if (b.command == CmdSetPose) begin
			pose_x = x; pose_y = y; pose_h = h;
		end else begin
			if (!seen_update) begin
				pose_x = x; pose_y = y; pose_h = h;
				seen_update = 1;
			end
			dx = x - pose_x;
			dy = y - pose_y;
			dth = wrap_angle(h - pose_h);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (ax >= 64'd1 << 31 || ay >= 64'd1 << 31) mag = 64'h7fffffff;
			else begin
				mag = int_sqrt(ax * ax + ay * ay);
				if (mag > 64'h7fffffff) mag = 64'h7fffffff;
			end
			r1 = wrap_angle(bearing(dy, dx) - pose_h);
			rev = (r1 < 0 ? -r1 : r1) > 12868;
			if (rev) r1 = wrap_angle(r1 - 25736);
			r2 = wrap_angle(dth - r1);
			mv = (mag >= move_min) || (longint'(dth < 0 ? -dth : dth) >= turn_min);
			if (mv) begin
				s = (int_sqrt((move_gain * mag) << 16) + 128) >> 8;
				hold_first = turn_spread(r1);
				hold_move = s > 16777215 ? 16777215 : s;
				hold_second = turn_spread(r2);
			end
			pose_x = x; pose_y = y; pose_h = h;
			r.moved = mv;
			r.translation = 32'(rev ? -longint'(mag) : longint'(mag));
			r.first_turn = 16'(r1);
			r.second_turn = 16'(r2);
		end
		r.first_turn_spread = 14'(hold_first);
		r.move_spread = 24'(hold_move);
		r.second_turn_spread = 14'(hold_second);
		return r;
	endfunction

	// write one register over APB and mirror it in the predictor
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			RegTurnGain: turn_gain = val[15:0];
			RegMoveGain: move_gain = val[15:0];
			RegMinMove:  move_min = val[30:0];
			default:     turn_min = val[14:0];
		endcase
	endtask

	// drop valid, then wait until every expected beat has come back
	task automatic drain();
		in_valid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	// offer one beat, hold it until accepted
	task automatic send_beat(in_beat_t b, bit may_idle);
		while (may_idle && $urandom_range(99) < 8) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_beat <= b;
		do @(posedge clk); while (in_stall);
		pending_q.push_back(decompose_pose(b));
	endtask

	function automatic in_beat_t rand_beat(longint cx, longint cy);
		in_beat_t b;
		int k;
		b.command = ($urandom_range(99) < 8) ? CmdSetPose : CmdUpdate;
		k = $urandom_range(9);
		if (k == 0) begin
			b.pos_x = $urandom;
			b.pos_y = $urandom;
		end else begin
			b.pos_x = 32'(cx + ($signed($urandom) >>> $urandom_range(31, 8)));
			b.pos_y = 32'(cy + ($signed($urandom) >>> $urandom_range(31, 8)));
		end
		b.heading = (k == 1) ? 16'($urandom) : 16'($urandom_range(51472) - 25736);
		return b;
	endfunction

	// result side: random stall, one long hold-off, compare each beat
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_beat.moved !== e.moved) begin
					$error("moved exp %0d got %0d", e.moved, out_beat.moved); errors++;
				end
				if (out_beat.translation !== e.translation) begin
					$error("translation exp %0d got %0d", e.translation, out_beat.translation);
					errors++;
				end
				if (out_beat.first_turn !== e.first_turn) begin
					$error("first_turn exp %0d got %0d", e.first_turn, out_beat.first_turn);
					errors++;
				end
				if (out_beat.second_turn !== e.second_turn) begin
					$error("second_turn exp %0d got %0d", e.second_turn, out_beat.second_turn);
					errors++;
				end
				if (out_beat.first_turn_spread !== e.first_turn_spread) begin
					$error("first_turn_spread exp %0d got %0d", e.first_turn_spread,
						out_beat.first_turn_spread); errors++;
				end
				if (out_beat.move_spread !== e.move_spread) begin
					$error("move_spread exp %0d got %0d", e.move_spread, out_beat.move_spread);
					errors++;
				end
				if (out_beat.second_turn_spread !== e.second_turn_spread) begin
					$error("second_turn_spread exp %0d got %0d", e.second_turn_spread,
						out_beat.second_turn_spread); errors++;
				end
			end
		end
		out_stall <= hold_off || (!quiet_out && $urandom_range(99) < 8);
	end

	typedef struct {
		in_beat_t  b;
		bit        known;
		out_beat_t r;
	} row_t;

	row_t rows[$];

	function automatic row_t mk(logic c, int x, int y, int h, bit known = 0,
			out_beat_t r = '0);
		row_t w;
		w.b.command = c; w.b.pos_x = x; w.b.pos_y = y; w.b.heading = 16'(h);
		w.known = known; w.r = r;
		return w;
	endfunction

	initial begin
		out_beat_t exp_r;
		out_beat_t first_r;
		in_beat_t b;
		longint unsigned cfg_sets[4][4];
		int n;
		arst_n = 0; in_valid = 0; in_beat = '0; out_stall = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		turn_gain = 328; move_gain = 1638; move_min = 164; turn_min = 164;
		pose_x = 0; pose_y = 0; pose_h = 0; seen_update = 0;
		hold_first = 0; hold_move = 0; hold_second = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// first update turns by minus the heading, then back again
		first_r = '0;
		first_r.first_turn = -16'sd100;
		first_r.second_turn = 16'sd100;

		// directed table: first update, set pose, extremes, reversing, saturation
		rows.push_back(mk(CmdSetPose, 0, 0, 0, 1, '0));
		rows.push_back(mk(CmdUpdate, 1000, 2000, 100, 1, first_r));
		rows.push_back(mk(CmdUpdate, 1000, 2000, 100));
		rows.push_back(mk(CmdUpdate, 70000, 2000, 100));
		rows.push_back(mk(CmdUpdate, 70000, 90000, 200));
		rows.push_back(mk(CmdUpdate, 0, 90000, 200));
		rows.push_back(mk(CmdUpdate, 0, 0, -25736));
		rows.push_back(mk(CmdUpdate, 0, 0, 25736));
		rows.push_back(mk(CmdUpdate, -65536, 0, 25736));
		rows.push_back(mk(CmdUpdate, 65536, 0, 0));
		rows.push_back(mk(CmdUpdate, 32'h7fffffff, 32'h7fffffff, 12868));
		rows.push_back(mk(CmdUpdate, 32'h80000000, 32'h80000000, -12868));
		rows.push_back(mk(CmdUpdate, 32'h7fffffff, 32'h80000000, 16'h7fff));
		rows.push_back(mk(CmdSetPose, 5, 5, 16'h8000));
		rows.push_back(mk(CmdUpdate, 5, 5, 0));
		rows.push_back(mk(CmdUpdate, 10, 3, 0));
		rows.push_back(mk(CmdUpdate, 10, 3, 164));
		rows.push_back(mk(CmdUpdate, 100, 3, 164));
		// check the typed rows, then rewind the predictor for the real run
		foreach (rows[i]) begin
			exp_r = decompose_pose(rows[i].b);
			if (rows[i].known && exp_r !== rows[i].r) begin
				$error("table row %0d disagrees with predictor", i);
				errors++;
			end
		end
		pose_x = 0; pose_y = 0; pose_h = 0; seen_update = 0;
		hold_first = 0; hold_move = 0; hold_second = 0;
		foreach (rows[i]) send_beat(rows[i].b, 1);
		drain();

		// random phases over several register settings, extremes included
		cfg_sets = '{'{328, 1638, 164, 164}, '{65535, 65535, 0, 0},
			'{0, 0, 32'h7fffffff, 25736}, '{12345, 40000, 65536, 800}};
		n = 0;
		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 4; r++) write_reg(r[1:0], cfg_sets[p][r]);
			quiet_out = (p == 1);
			for (int k = 0; k < NumRandom / 4; k++) begin
				b = rand_beat(pose_x, pose_y);
				if (p == 2 && k == 20) begin
					fork
						begin
							hold_off = 1;
							repeat (1500) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				send_beat(b, p != 1);
				n++;
			end
			drain();
		end

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
rtl/omd_pkg.sv
rtl/omd_cordic_cell.sv
rtl/omd_isqrt.sv
rtl/odometry_motion_decompose.sv
tb/testbench.sv
